/* rtl/srctok_pkg.sv */
// ----------------------------------------------------------------------------
// srctok_pkg
// Shared types, codes and helper functions of the source tokenizer.
// ----------------------------------------------------------------------------
package srctok_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int LENGTH_BITS_DEF   = 8;
    localparam int QUEUE_DEPTH       = 4;
    localparam int KIND_BITS         = 4;
    localparam int WIDTH_CODE_BITS   = 3;
    localparam int KW_LEN            = 6;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_LPAREN  = 4'd0,
        KIND_RPAREN  = 4'd1,
        KIND_LBRACE  = 4'd2,
        KIND_RBRACE  = 4'd3,
        KIND_SEMI    = 4'd4,
        KIND_RETURN  = 4'd5,
        KIND_TYPE    = 4'd6,
        KIND_NUMBER  = 4'd7,
        KIND_IDENT   = 4'd8,
        KIND_UNKNOWN = 4'd9
    } kind_t;

    // integer type prefix tracker
    typedef enum logic [3:0] {
        TM_NONE = 4'd0,
        TM_I    = 4'd1,
        TM_I8   = 4'd2,
        TM_I1   = 4'd3,
        TM_I16  = 4'd4,
        TM_I3   = 4'd5,
        TM_I32  = 4'd6,
        TM_I6   = 4'd7,
        TM_I64  = 4'd8,
        TM_I12  = 4'd9,
        TM_I128 = 4'd10,
        TM_BAD  = 4'd11
    } type_state_t;

    localparam logic [WIDTH_CODE_BITS-1:0] WC_8   = 3'd0;
    localparam logic [WIDTH_CODE_BITS-1:0] WC_16  = 3'd1;
    localparam logic [WIDTH_CODE_BITS-1:0] WC_32  = 3'd2;
    localparam logic [WIDTH_CODE_BITS-1:0] WC_64  = 3'd3;
    localparam logic [WIDTH_CODE_BITS-1:0] WC_128 = 3'd4;

    // one queue entry: a finished word and/or a one-byte punctuation token
    typedef struct packed {
        logic                       has_word;
        kind_t                      word_kind;
        logic [WIDTH_CODE_BITS-1:0] word_wc;
        logic                       has_punct;
        kind_t                      punct_kind;
    } tok_ctl_t;

    function automatic logic [7:0] kw_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0: c = 8'h72;  // r
            3'd1: c = 8'h65;  // e
            3'd2: c = 8'h74;  // t
            3'd3: c = 8'h75;  // u
            3'd4: c = 8'h72;  // r
            3'd5: c = 8'h6e;  // n
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic type_state_t type_step(input type_state_t s, input logic [7:0] c,
                                              input logic is_dig);
        type_state_t n;
        n = TM_BAD;
        if (s == TM_NONE || !is_dig) begin
            n = TM_NONE;
        end else begin
            case (s)
                TM_I: begin
                    if (c == 8'h38) n = TM_I8;
                    else if (c == 8'h31) n = TM_I1;
                    else if (c == 8'h33) n = TM_I3;
                    else if (c == 8'h36) n = TM_I6;
                end
                TM_I1: begin
                    if (c == 8'h36) n = TM_I16;
                    else if (c == 8'h32) n = TM_I12;
                end
                TM_I3: begin
                    if (c == 8'h32) n = TM_I32;
                end
                TM_I6: begin
                    if (c == 8'h34) n = TM_I64;
                end
                TM_I12: begin
                    if (c == 8'h38) n = TM_I128;
                end
                default: n = TM_BAD;
            endcase
        end
        return n;
    endfunction

endpackage

/* rtl/source_tokenizer.sv */
// ----------------------------------------------------------------------------
// source_tokenizer
// Byte-serial tokenizer: source bytes in, classified tokens out.
// ----------------------------------------------------------------------------
// Input stream: one source byte per word in s_tdata; s_tuser set marks end
// of source, which flushes any word in progress and restarts offsets at 0.
// Output stream: one token per word; m_tuser carries the token kind,
// m_tdata its width code, start offset and length; m_tlast is set on the
// final token caused by one input word.
// A byte is taken every cycle while the four-entry token queue has room.
// A token is written into the token queue and then loaded into the output register before it appears on m_tvalid.
// The emitter sends one token per cycle while m_tready is high, so an input
// that ends a word with punctuation yields two tokens; the queue absorbs short
// bursts of these, and sustained input rate is one byte per cycle as long as
// results average at most one token per byte.
// When m_tready is low the output register holds, the queue fills and
// s_tready drops once it is full.
// Reset clears the position counter, the word state and the queue.
// ----------------------------------------------------------------------------
module source_tokenizer #(
    parameter int POSITION_BITS = srctok_pkg::POSITION_BITS_DEF,
    parameter int LENGTH_BITS   = srctok_pkg::LENGTH_BITS_DEF,
    localparam int M_DATA_BITS  =
        ((srctok_pkg::WIDTH_CODE_BITS + POSITION_BITS + LENGTH_BITS + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // char_code
    input  logic [0:0]             s_tuser,   // end_marker
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_DATA_BITS-1:0] m_tdata,   // width_code, token_start, token_length
    output logic [3:0]             m_tuser,   // token_kind
    output logic                   m_tlast
);

    localparam int CTL_BITS = $bits(srctok_pkg::tok_ctl_t);
    localparam int Q_BITS   = CTL_BITS + 2 * POSITION_BITS + LENGTH_BITS;
    localparam int PAD_BITS =
        M_DATA_BITS - srctok_pkg::WIDTH_CODE_BITS - POSITION_BITS - LENGTH_BITS;

    srctok_pkg::tok_ctl_t     f_ctl, b_ctl;
    logic [POSITION_BITS-1:0] f_word_start, b_word_start;
    logic [LENGTH_BITS-1:0]   f_word_length, b_word_length;
    logic [POSITION_BITS-1:0] f_punct_pos, b_punct_pos;
    logic                     f_push, q_not_full, q_not_empty, q_pop;
    logic [Q_BITS-1:0]        q_head;

    srctok_pkg::kind_t        out_kind;
    logic [srctok_pkg::WIDTH_CODE_BITS-1:0] out_wc;
    logic [POSITION_BITS-1:0] out_start;
    logic [LENGTH_BITS-1:0]   out_length;

    srctok_front #(
        .POSITION_BITS (POSITION_BITS),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .char_code     (s_tdata),
        .end_marker    (s_tuser[0]),
        .q_ready       (q_not_full),
        .q_push        (f_push),
        .q_ctl         (f_ctl),
        .q_word_start  (f_word_start),
        .q_word_length (f_word_length),
        .q_punct_pos   (f_punct_pos)
    );

    srctok_queue #(
        .DATA_BITS (Q_BITS)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (f_push),
        .push_data ({f_punct_pos, f_word_length, f_word_start, f_ctl}),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_data (q_head)
    );

    assign {b_punct_pos, b_word_length, b_word_start, b_ctl} = q_head;

    srctok_back #(
        .POSITION_BITS (POSITION_BITS),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_not_empty),
        .q_pop         (q_pop),
        .q_ctl         (b_ctl),
        .q_word_start  (b_word_start),
        .q_word_length (b_word_length),
        .q_punct_pos   (b_punct_pos),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_kind      (out_kind),
        .out_wc        (out_wc),
        .out_start     (out_start),
        .out_length    (out_length),
        .out_last      (m_tlast)
    );

    assign m_tuser = out_kind;
    assign m_tdata = {{PAD_BITS{1'b0}}, out_length, out_start, out_wc};

endmodule

/* rtl/srctok_front.sv */
// ----------------------------------------------------------------------------
// srctok_front
// Takes one source byte per cycle while the token queue has room, tracks the
// word in progress and pushes finished words and punctuation tokens into the queue.
// ----------------------------------------------------------------------------
module srctok_front #(
    parameter int POSITION_BITS = srctok_pkg::POSITION_BITS_DEF,
    parameter int LENGTH_BITS   = srctok_pkg::LENGTH_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [7:0]               char_code,
    input  logic                     end_marker,
    input  logic                     q_ready,
    output logic                     q_push,
    output srctok_pkg::tok_ctl_t     q_ctl,
    output logic [POSITION_BITS-1:0] q_word_start,
    output logic [LENGTH_BITS-1:0]   q_word_length,
    output logic [POSITION_BITS-1:0] q_punct_pos
);

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_I      = 8'h69;
    localparam logic [7:0] CH_R      = 8'h72;

    logic [POSITION_BITS-1:0]  position_reg, position_next;
    logic                      in_word_reg, in_word_next;
    logic [POSITION_BITS-1:0]  word_start_reg, word_start_next;
    logic [LENGTH_BITS-1:0]    word_len_reg, word_len_next;
    logic                      all_digits_reg, all_digits_next;
    logic                      all_letters_reg, all_letters_next;
    logic                      minus_reg, minus_next;
    logic                      kw_reg, kw_next;
    srctok_pkg::type_state_t   tm_reg, tm_next;

    logic                      accept;
    logic                      is_sep, is_punct, is_dig, is_let;
    srctok_pkg::kind_t         punct_kind;
    srctok_pkg::kind_t         word_kind;
    logic [srctok_pkg::WIDTH_CODE_BITS-1:0] word_wc;

    assign in_ready = q_ready;
    assign accept   = in_valid && q_ready;

    assign is_sep = (char_code == CH_SPACE) || (char_code == CH_CR) ||
                    (char_code == CH_TAB) || (char_code == CH_LF);
    assign is_punct = (char_code == CH_LPAREN) || (char_code == CH_RPAREN) ||
                      (char_code == CH_LBRACE) || (char_code == CH_RBRACE) ||
                      (char_code == CH_SEMI);
    assign is_dig = (char_code >= 8'h30) && (char_code <= 8'h39);
    assign is_let = ((char_code >= 8'h61) && (char_code <= 8'h7a)) ||
                    ((char_code >= 8'h41) && (char_code <= 8'h5a));

    always_comb begin
        case (char_code)
            CH_LPAREN: punct_kind = srctok_pkg::KIND_LPAREN;
            CH_RPAREN: punct_kind = srctok_pkg::KIND_RPAREN;
            CH_LBRACE: punct_kind = srctok_pkg::KIND_LBRACE;
            CH_RBRACE: punct_kind = srctok_pkg::KIND_RBRACE;
            default:   punct_kind = srctok_pkg::KIND_SEMI;
        endcase
    end

    // classification of the word held in the state registers
    always_comb begin
        word_kind = srctok_pkg::KIND_UNKNOWN;
        word_wc   = srctok_pkg::WC_8;
        if (kw_reg && word_len_reg == LENGTH_BITS'(srctok_pkg::KW_LEN)) begin
            word_kind = srctok_pkg::KIND_RETURN;
        end else begin
            case (tm_reg)
                srctok_pkg::TM_I8: begin
                    word_kind = srctok_pkg::KIND_TYPE;
                    word_wc   = srctok_pkg::WC_8;
                end
                srctok_pkg::TM_I16: begin
                    word_kind = srctok_pkg::KIND_TYPE;
                    word_wc   = srctok_pkg::WC_16;
                end
                srctok_pkg::TM_I32: begin
                    word_kind = srctok_pkg::KIND_TYPE;
                    word_wc   = srctok_pkg::WC_32;
                end
                srctok_pkg::TM_I64: begin
                    word_kind = srctok_pkg::KIND_TYPE;
                    word_wc   = srctok_pkg::WC_64;
                end
                srctok_pkg::TM_I128: begin
                    word_kind = srctok_pkg::KIND_TYPE;
                    word_wc   = srctok_pkg::WC_128;
                end
                srctok_pkg::TM_NONE, srctok_pkg::TM_I: begin
                    if (all_digits_reg ||
                        (minus_reg && word_len_reg >= LENGTH_BITS'(2))) begin
                        word_kind = srctok_pkg::KIND_NUMBER;
                    end else if (all_letters_reg) begin
                        word_kind = srctok_pkg::KIND_IDENT;
                    end
                end
                default: word_kind = srctok_pkg::KIND_UNKNOWN;
            endcase
        end
    end

    always_comb begin
        position_next    = position_reg;
        in_word_next     = in_word_reg;
        word_start_next  = word_start_reg;
        word_len_next    = word_len_reg;
        all_digits_next  = all_digits_reg;
        all_letters_next = all_letters_reg;
        minus_next       = minus_reg;
        kw_next          = kw_reg;
        tm_next          = tm_reg;

        q_push               = 1'b0;
        q_ctl.has_word       = in_word_reg;
        q_ctl.word_kind      = word_kind;
        q_ctl.word_wc        = word_wc;
        q_ctl.has_punct      = 1'b0;
        q_ctl.punct_kind     = punct_kind;
        q_word_start         = word_start_reg;
        q_word_length        = word_len_reg;
        q_punct_pos          = position_reg;

        if (accept) begin
            if (end_marker || is_sep || is_punct) begin
                q_push           = in_word_reg || (is_punct && !end_marker);
                q_ctl.has_punct  = is_punct && !end_marker;
                in_word_next     = 1'b0;
                word_start_next  = '0;
                word_len_next    = '0;
                all_digits_next  = 1'b1;
                all_letters_next = 1'b1;
                minus_next       = 1'b0;
                kw_next          = 1'b1;
                tm_next          = srctok_pkg::TM_NONE;
                position_next    = end_marker ? '0 : position_reg + POSITION_BITS'(1);
            end else begin
                if (!in_word_reg) begin
                    in_word_next     = 1'b1;
                    word_start_next  = position_reg;
                    word_len_next    = LENGTH_BITS'(1);
                    all_digits_next  = is_dig;
                    all_letters_next = is_let;
                    minus_next       = (char_code == CH_MINUS);
                    kw_next          = (char_code == CH_R);
                    tm_next          = (char_code == CH_I) ? srctok_pkg::TM_I
                                                           : srctok_pkg::TM_NONE;
                end else begin
                    kw_next = kw_reg &&
                              (word_len_reg < LENGTH_BITS'(srctok_pkg::KW_LEN)) &&
                              (char_code == srctok_pkg::kw_char(word_len_reg[2:0]));
                    minus_next       = minus_reg && is_dig;
                    all_digits_next  = all_digits_reg && is_dig;
                    all_letters_next = all_letters_reg && is_let;
                    tm_next          = srctok_pkg::type_step(tm_reg, char_code, is_dig);
                    if (word_len_reg != '1) begin
                        word_len_next = word_len_reg + LENGTH_BITS'(1);
                    end
                end
                position_next = position_reg + POSITION_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg    <= '0;
            in_word_reg     <= 1'b0;
            word_start_reg  <= '0;
            word_len_reg    <= '0;
            all_digits_reg  <= 1'b1;
            all_letters_reg <= 1'b1;
            minus_reg       <= 1'b0;
            kw_reg          <= 1'b1;
            tm_reg          <= srctok_pkg::TM_NONE;
        end else begin
            position_reg    <= position_next;
            in_word_reg     <= in_word_next;
            word_start_reg  <= word_start_next;
            word_len_reg    <= word_len_next;
            all_digits_reg  <= all_digits_next;
            all_letters_reg <= all_letters_next;
            minus_reg       <= minus_next;
            kw_reg          <= kw_next;
            tm_reg          <= tm_next;
        end
    end

endmodule

/* rtl/srctok_queue.sv */
// ----------------------------------------------------------------------------
// srctok_queue
// Small FIFO of token entries between the classifier and the emitter.
// ----------------------------------------------------------------------------
module srctok_queue #(
    parameter int DATA_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  logic [DATA_BITS-1:0] push_data,
    output logic                 not_full,
    input  logic                 pop,
    output logic                 not_empty,
    output logic [DATA_BITS-1:0] head_data
);

    localparam int DEPTH    = srctok_pkg::QUEUE_DEPTH;
    localparam int PTR_BITS = $clog2(DEPTH);

    logic [DATA_BITS-1:0] entry_reg [DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_BITS:0]    count_reg, count_next;
    logic                 do_push, do_pop;

    assign not_full  = (count_reg != (PTR_BITS+1)'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign head_data = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + PTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + (PTR_BITS+1)'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - (PTR_BITS+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/srctok_back.sv */
// ----------------------------------------------------------------------------
// srctok_back
// Splits each queue entry into one or two tokens and drives the output
// register of the result stream.
// ----------------------------------------------------------------------------
module srctok_back #(
    parameter int POSITION_BITS = srctok_pkg::POSITION_BITS_DEF,
    parameter int LENGTH_BITS   = srctok_pkg::LENGTH_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     q_valid,
    output logic                     q_pop,
    input  srctok_pkg::tok_ctl_t     q_ctl,
    input  logic [POSITION_BITS-1:0] q_word_start,
    input  logic [LENGTH_BITS-1:0]   q_word_length,
    input  logic [POSITION_BITS-1:0] q_punct_pos,
    output logic                     out_valid,
    input  logic                     out_ready,
    output srctok_pkg::kind_t        out_kind,
    output logic [srctok_pkg::WIDTH_CODE_BITS-1:0] out_wc,
    output logic [POSITION_BITS-1:0] out_start,
    output logic [LENGTH_BITS-1:0]   out_length,
    output logic                     out_last
);

    logic                     valid_reg, valid_next;
    logic                     phase_reg, phase_next;  // word of entry already sent
    srctok_pkg::kind_t        kind_reg, kind_next;
    logic [srctok_pkg::WIDTH_CODE_BITS-1:0] wc_reg, wc_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [LENGTH_BITS-1:0]   length_reg, length_next;
    logic                     last_reg, last_next;
    logic                     load;

    assign load = q_valid && (!valid_reg || out_ready);

    always_comb begin
        valid_next  = valid_reg && !out_ready;
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        wc_next     = wc_reg;
        start_next  = start_reg;
        length_next = length_reg;
        last_next   = last_reg;
        q_pop       = 1'b0;
        if (load) begin
            valid_next = 1'b1;
            if (q_ctl.has_word && !phase_reg) begin
                kind_next   = q_ctl.word_kind;
                wc_next     = q_ctl.word_wc;
                start_next  = q_word_start;
                length_next = q_word_length;
                last_next   = !q_ctl.has_punct;
                phase_next  = q_ctl.has_punct;
                q_pop       = !q_ctl.has_punct;
            end else begin
                kind_next   = q_ctl.punct_kind;
                wc_next     = srctok_pkg::WC_8;
                start_next  = q_punct_pos;
                length_next = LENGTH_BITS'(1);
                last_next   = 1'b1;
                phase_next  = 1'b0;
                q_pop       = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        wc_reg     <= wc_next;
        start_reg  <= start_next;
        length_reg <= length_next;
        last_reg   <= last_next;
    end

    assign out_valid  = valid_reg;
    assign out_kind   = kind_reg;
    assign out_wc     = wc_reg;
    assign out_start  = start_reg;
    assign out_length = length_reg;
    assign out_last   = last_reg;

endmodule
